// ===== hw/rtl/csv_tok_pkg.sv =====
`default_nettype none
package csv_tok_pkg;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DELIM_W = 3;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } t_kind;

    typedef enum logic {
        OP_CHAR    = 1'b0,
        OP_ROW_END = 1'b1
    } t_op;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    localparam int unsigned DEN_SEMI  = 0;
    localparam int unsigned DEN_COMMA = 1;
    localparam int unsigned DEN_TAB   = 2;

    localparam logic [DELIM_W-1:0] DELIM_RESET = 3'd1;

    localparam logic [APB_AW-1:0] ADDR_DELIM_EN = 3'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage
`default_nettype wire

// ===== hw/rtl/csv_tok_if.sv =====
`default_nettype none
interface csv_tok_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [csv_tok_pkg::BYTE_W-1:0] char_in;

    modport source (output valid, output op, output char_in, input ready);
    modport sink (input valid, input op, input char_in, output ready);
endinterface

interface csv_tok_out_if;
    logic                           valid;
    logic                           ready;
    logic [csv_tok_pkg::KIND_W-1:0] kind;
    logic [csv_tok_pkg::BYTE_W-1:0] data_out;
    logic                           last;

    modport source (output valid, output kind, output data_out, output last, input ready);
    modport sink (input valid, input kind, input data_out, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csv_tok_apb.sv =====
`default_nettype none
module csv_tok_apb (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [csv_tok_pkg::APB_AW-1:0]  paddr,
    input  wire logic [csv_tok_pkg::APB_DW-1:0]  pwdata,
    output logic      [csv_tok_pkg::APB_DW-1:0]  prdata,
    output logic                                 pready,
    output logic      [csv_tok_pkg::DELIM_W-1:0] o_delim_en
);
    import csv_tok_pkg::*;

    logic [DELIM_W-1:0] r_delim_en;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_en <= DELIM_RESET;
        end else if (wr_en && (paddr[APB_AW-1:2] == ADDR_DELIM_EN[APB_AW-1:2])) begin
            r_delim_en <= pwdata[DELIM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == ADDR_DELIM_EN[APB_AW-1:2]) begin
            prdata = {{(APB_DW-DELIM_W){1'b0}}, r_delim_en};
        end
    end

    assign o_delim_en = r_delim_en;
endmodule
`default_nettype wire

// ===== hw/rtl/csv_tok_core.sv =====
`default_nettype none
module csv_tok_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_op,
    input  wire logic [csv_tok_pkg::BYTE_W-1:0]  i_char,
    input  wire logic [csv_tok_pkg::DELIM_W-1:0] i_delim_en,
    output csv_tok_pkg::t_push                   o_push
);
    import csv_tok_pkg::*;

    logic r_in_value, n_in_value;
    logic r_after_delim, n_after_delim;
    logic r_quoted, n_quoted;
    logic r_quote_pend, n_quote_pend;
    logic is_delim;
    t_push push;

    assign is_delim = ((i_char == CH_SEMI)  && i_delim_en[DEN_SEMI])  ||
                      ((i_char == CH_COMMA) && i_delim_en[DEN_COMMA]) ||
                      ((i_char == CH_TAB)   && i_delim_en[DEN_TAB]);

    always_comb begin
        n_in_value    = r_in_value;
        n_after_delim = r_after_delim;
        n_quoted      = r_quoted;
        n_quote_pend  = r_quote_pend;
        push          = '0;
        if (i_fire) begin
            if (i_op == OP_ROW_END) begin
                if (r_in_value || r_after_delim) begin
                    push.cnt  = 2'd2;
                    push.res0 = '{kind: KIND_FIELD_END, data: '0, last: 1'b0};
                    push.res1 = '{kind: KIND_ROW_END, data: '0, last: 1'b1};
                end else begin
                    push.cnt  = 2'd1;
                    push.res0 = '{kind: KIND_ROW_END, data: '0, last: 1'b1};
                end
                n_in_value    = 1'b0;
                n_after_delim = 1'b0;
                n_quoted      = 1'b0;
                n_quote_pend  = 1'b0;
            end else if (i_char == CH_QUOTE) begin
                n_after_delim = 1'b0;
                if (r_in_value) begin
                    if (r_quoted) begin
                        n_quote_pend = !r_quote_pend;
                        if (r_quote_pend) begin
                            push.cnt  = 2'd1;
                            push.res0 = '{kind: KIND_DATA, data: CH_QUOTE, last: 1'b1};
                        end
                    end else begin
                        push.cnt  = 2'd1;
                        push.res0 = '{kind: KIND_DATA, data: CH_QUOTE, last: 1'b1};
                    end
                end else begin
                    n_quoted     = 1'b1;
                    n_in_value   = 1'b1;
                    n_quote_pend = 1'b0;
                end
            end else if (!r_quoted) begin
                push.cnt = 2'd1;
                if (is_delim) begin
                    n_in_value    = 1'b0;
                    n_after_delim = 1'b1;
                    push.res0     = '{kind: KIND_FIELD_END, data: '0, last: 1'b1};
                end else if ((i_char == CH_LF) || (i_char == CH_CR)) begin
                    push.res0 = '{kind: KIND_DATA, data: CH_SPACE, last: 1'b1};
                end else begin
                    n_in_value    = 1'b1;
                    n_after_delim = 1'b0;
                    push.res0     = '{kind: KIND_DATA, data: i_char, last: 1'b1};
                end
            end else begin
                n_after_delim = 1'b0;
                push.cnt      = 2'd1;
                if (r_in_value && r_quote_pend) begin
                    n_in_value   = 1'b0;
                    n_quoted     = 1'b0;
                    n_quote_pend = 1'b0;
                    push.res0    = '{kind: KIND_FIELD_END, data: '0, last: 1'b1};
                end else begin
                    n_in_value = 1'b1;
                    push.res0  = '{kind: KIND_DATA, data: i_char, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value    <= 1'b0;
            r_after_delim <= 1'b0;
            r_quoted      <= 1'b0;
            r_quote_pend  <= 1'b0;
        end else begin
            r_in_value    <= n_in_value;
            r_after_delim <= n_after_delim;
            r_quoted      <= n_quoted;
            r_quote_pend  <= n_quote_pend;
        end
    end

    assign o_push = push;
endmodule
`default_nettype wire

// ===== hw/rtl/csv_tok_fifo.sv =====
`default_nettype none
module csv_tok_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  csv_tok_pkg::t_push  i_push,
    output logic                o_space,
    output logic                o_valid,
    input  wire logic           i_ready,
    output csv_tok_pkg::t_result o_head
);
    import csv_tok_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] SPACE_MAX = CW'(DEPTH - 2);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_result         mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   wr_next;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PTR_LAST) ? '0 : p + PW'(1);
        return q;
    endfunction

    assign wr_next = ptr_inc(r_wr);
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        n_wr    = r_wr;
        n_count = r_count - CW'(pop);
        case (i_push.cnt)
            2'd1: begin
                n_wr    = wr_next;
                n_count = n_count + CW'(1);
            end
            2'd2: begin
                n_wr    = ptr_inc(wr_next);
                n_count = n_count + CW'(2);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_space = (r_count <= SPACE_MAX);
    assign o_valid = (r_count != '0);
    assign o_head  = mem[r_rd];
endmodule
`default_nettype wire

// ===== hw/rtl/csv_row_tokenizer_unit.sv =====
`default_nettype none
// A word accepted at the input goes via the input register to the result queue.
// Throughput: one input word per cycle while the result queue has room for two
// words; an end-of-row word that closes a field yields two output words,
// drained one per cycle from the FIFO_DEPTH result queue while ready is high.
// Reset: synchronous, active low; clears all flags and the queue, and sets the
// delimiter enables to semicolon only.
module csv_row_tokenizer_unit #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    csv_tok_in_if.sink                           i_in,
    csv_tok_out_if.source                        o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [csv_tok_pkg::APB_AW-1:0]  paddr,
    input  wire logic [csv_tok_pkg::APB_DW-1:0]  pwdata,
    output logic      [csv_tok_pkg::APB_DW-1:0]  prdata,
    output logic                                 pready
);
    import csv_tok_pkg::*;

    logic               r_in_valid;
    logic               r_in_op;
    logic [BYTE_W-1:0]  r_in_char;
    logic               fire;
    logic               space;
    logic [DELIM_W-1:0] delim_en;
    t_push              push;
    t_result            head;

    assign fire       = r_in_valid && space;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.op;
            r_in_char <= i_in.char_in;
        end
    end

    csv_tok_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_delim_en (delim_en)
    );

    csv_tok_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in_op),
        .i_char     (r_in_char),
        .i_delim_en (delim_en),
        .o_push     (push)
    );

    csv_tok_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    assign o_out.kind     = head.kind;
    assign o_out.data_out = head.data;
    assign o_out.last     = head.last;
endmodule
`default_nettype wire

// ===== sim/csv_row_tokenizer_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module csv_row_tokenizer_unit_test;
    import csv_tok_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned HOLD_AT         = 300;
    localparam int unsigned HOLD_BACKLOG    = 16;
    localparam int unsigned ITEMS_PER_PHASE = 66;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned BURST_PHASE     = 2;
    localparam int unsigned STRAY_PHASE     = 4;
    localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'd4;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] ch;
    } t_row_byte;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    csv_tok_in_if  in_bus ();
    csv_tok_out_if out_bus ();

    csv_row_tokenizer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_row_byte          pending_bytes[$];
    t_result            expected_words[$];
    logic [DELIM_W-1:0] delim_en;
    logic [DELIM_W-1:0] delim_plan [PHASES] = '{3'd7, 3'd0, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd1};
    bit                 tk_in_value;
    bit                 tk_after_delim;
    bit                 tk_quoted;
    bit                 tk_quote_pend;
    bit                 word_held;
    bit                 no_idle;
    bit                 failed;
    bit                 hold_done;
    int                 send_gap;
    int                 stall_left;
    int                 hold_left;
    int unsigned        idle_cycles;
    int unsigned        bytes_taken;

    function automatic int gap_len();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            n = 0;
        end else if (r < 92) begin
            n = $urandom_range(1, 3);
        end else begin
            n = $urandom_range(4, 30);
        end
        return n;
    endfunction

    function bit is_delim(logic [BYTE_W-1:0] ch);
        return (ch == CH_SEMI && delim_en[DEN_SEMI]) ||
               (ch == CH_COMMA && delim_en[DEN_COMMA]) ||
               (ch == CH_TAB && delim_en[DEN_TAB]);
    endfunction

    function void push_word(t_kind kind, logic [BYTE_W-1:0] data, logic last);
        t_result w;
        w.kind = kind;
        w.data = data;
        w.last = last;
        expected_words.push_back(w);
    endfunction

    function void tokenize(t_op op, logic [BYTE_W-1:0] ch);
        if (op == OP_ROW_END) begin
            if (tk_in_value || tk_after_delim) begin
                push_word(KIND_FIELD_END, '0, 1'b0);
            end
            push_word(KIND_ROW_END, '0, 1'b1);
            tk_in_value    = 0;
            tk_after_delim = 0;
            tk_quoted      = 0;
            tk_quote_pend  = 0;
        end else if (ch == CH_QUOTE) begin
            tk_after_delim = 0;
            if (tk_in_value) begin
                if (tk_quoted) begin
                    tk_quote_pend = !tk_quote_pend;
                    if (!tk_quote_pend) begin
                        push_word(KIND_DATA, CH_QUOTE, 1'b1);
                    end
                end else begin
                    push_word(KIND_DATA, CH_QUOTE, 1'b1);
                end
            end else begin
                tk_quoted     = 1;
                tk_in_value   = 1;
                tk_quote_pend = 0;
            end
        end else if (!tk_quoted) begin
            if (is_delim(ch)) begin
                tk_in_value    = 0;
                tk_after_delim = 1;
                push_word(KIND_FIELD_END, '0, 1'b1);
            end else if (ch == CH_LF || ch == CH_CR) begin
                push_word(KIND_DATA, CH_SPACE, 1'b1);
            end else begin
                tk_in_value    = 1;
                tk_after_delim = 0;
                push_word(KIND_DATA, ch, 1'b1);
            end
        end else begin
            tk_after_delim = 0;
            if (tk_in_value && tk_quote_pend) begin
                tk_in_value   = 0;
                tk_quoted     = 0;
                tk_quote_pend = 0;
                push_word(KIND_FIELD_END, '0, 1'b1);
            end else begin
                tk_in_value = 1;
                push_word(KIND_DATA, ch, 1'b1);
            end
        end
    endfunction

    function void add_byte(t_op op, logic [BYTE_W-1:0] ch);
        t_row_byte b;
        b.op = op;
        b.ch = ch;
        pending_bytes.push_back(b);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_plain();
        logic [BYTE_W-1:0] ch;
        if ($urandom_range(0, 9) == 0) begin
            ch = $urandom_range(0, 1) ? CH_CR : CH_LF;
        end else begin
            ch = BYTE_W'($urandom_range(8'h20, 8'h7E));
            if (ch == CH_QUOTE || is_delim(ch)) begin
                ch = 8'h5F;
            end
        end
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_delim_char();
        logic [BYTE_W-1:0] ch;
        case ($urandom_range(0, 2))
            0: begin
                ch = CH_SEMI;
            end
            1: begin
                ch = CH_COMMA;
            end
            default: begin
                ch = CH_TAB;
            end
        endcase
        return ch;
    endfunction

    function void add_quoted_field();
        int n;
        int r;
        logic [BYTE_W-1:0] ch;
        n = $urandom_range(0, 5);
        add_byte(OP_CHAR, CH_QUOTE);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                add_byte(OP_CHAR, CH_QUOTE);
                add_byte(OP_CHAR, CH_QUOTE);
            end else if (r < 30) begin
                add_byte(OP_CHAR, pick_delim_char());
            end else if (r < 40) begin
                add_byte(OP_CHAR, $urandom_range(0, 1) ? CH_CR : CH_LF);
            end else begin
                ch = BYTE_W'($urandom_range(0, 255));
                add_byte(OP_CHAR, (ch == CH_QUOTE) ? 8'h27 : ch);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            add_byte(OP_CHAR, CH_QUOTE);
        end
    endfunction

    function void add_row();
        int nf;
        int n;
        int r;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) begin
                add_byte(OP_CHAR, pick_delim_char());
            end
            r = $urandom_range(0, 99);
            n = $urandom_range(0, 5);
            if (r < 45) begin
                for (int i = 0; i < n; i++) begin
                    add_byte(OP_CHAR, pick_plain());
                end
            end else if (r < 85) begin
                add_quoted_field();
            end else begin
                for (int i = 0; i < n; i++) begin
                    add_byte(t_op'($urandom_range(0, 7) == 0),
                             BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            add_byte(OP_ROW_END, BYTE_W'($urandom_range(0, 255)));
        end
    endfunction

    function void add_directed();
        add_byte(OP_ROW_END, 8'h00);
        add_byte(OP_CHAR, 8'h61);
        add_byte(OP_CHAR, 8'h00);
        add_byte(OP_CHAR, 8'hFF);
        add_byte(OP_CHAR, CH_SEMI);
        add_byte(OP_CHAR, 8'h62);
        add_byte(OP_CHAR, CH_QUOTE);
        add_byte(OP_CHAR, CH_LF);
        add_byte(OP_CHAR, CH_CR);
        add_byte(OP_CHAR, CH_COMMA);
        add_byte(OP_ROW_END, 8'h00);
        add_byte(OP_CHAR, CH_QUOTE);
        add_byte(OP_CHAR, CH_SEMI);
        add_byte(OP_CHAR, CH_LF);
        add_byte(OP_CHAR, CH_CR);
        add_byte(OP_CHAR, CH_QUOTE);
        add_byte(OP_CHAR, CH_QUOTE);
        add_byte(OP_CHAR, CH_QUOTE);
        add_byte(OP_CHAR, 8'h78);
        add_byte(OP_ROW_END, 8'h00);
        add_byte(OP_CHAR, CH_SEMI);
        add_byte(OP_ROW_END, 8'hFF);
    endfunction

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] wdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [APB_AW-1:0] addr, input logic [DELIM_W-1:0] want);
        logic [APB_DW-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DW'(want)) begin
            $display("%0t: delimiter enables expected %0h got %0h", $time, want, rd);
            failed = 1;
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || word_held || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        logic [APB_DW-1:0] wdata;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_bus.valid    = 1'b0;
        in_bus.op       = OP_CHAR;
        in_bus.char_in  = '0;
        out_bus.ready   = 1'b0;
        delim_en        = DELIM_RESET;
        delim_plan[PHASES-1] = DELIM_W'($urandom_range(0, 7));
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        apb_check(ADDR_DELIM_EN, DELIM_RESET);
        add_directed();
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            // unused upper bits must be masked off
            wdata = $urandom();
            wdata[DELIM_W-1:0] = delim_plan[p];
            apb_write(ADDR_DELIM_EN, wdata);
            delim_en = delim_plan[p];
            apb_check(ADDR_DELIM_EN, delim_en);
            if (p == STRAY_PHASE) begin
                apb_write(ADDR_UNUSED, $urandom());
                apb_check(ADDR_DELIM_EN, delim_en);
            end
            no_idle = (p == BURST_PHASE);
            while (pending_bytes.size() < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_byte(t_op'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
                end else begin
                    add_row();
                end
            end
        end
        wait_idle();
        if (failed) begin
            $display("csv_row_tokenizer_unit_test: errors");
        end else begin
            $display("csv_row_tokenizer_unit_test: clean");
        end
        $finish;
    end

    always @(negedge i_clk) begin : feed
        t_row_byte nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!word_held) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                nxt = pending_bytes.pop_front();
                in_bus.valid   <= 1'b1;
                in_bus.op      <= nxt.op;
                in_bus.char_in <= nxt.ch;
                word_held = 1;
                send_gap  = no_idle ? 0 : gap_len();
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            // hold off once so the result queue fills and stalls the input
            if (!hold_done && bytes_taken >= HOLD_AT &&
                pending_bytes.size() >= HOLD_BACKLOG) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                tokenize(t_op'(in_bus.op), in_bus.char_in);
                word_held = 0;
                bytes_taken++;
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word kind %0d data %0h last %0b", $time,
                             out_bus.kind, out_bus.data_out, out_bus.last);
                    failed = 1;
                end else begin
                    want = expected_words.pop_front();
                    if (out_bus.kind !== want.kind) begin
                        $display("%0t: kind expected %0d got %0d", $time,
                                 want.kind, out_bus.kind);
                        failed = 1;
                    end
                    if (out_bus.data_out !== want.data) begin
                        $display("%0t: data expected %0h got %0h", $time,
                                 want.data, out_bus.data_out);
                        failed = 1;
                    end
                    if (out_bus.last !== want.last) begin
                        $display("%0t: last expected %0b got %0b", $time,
                                 want.last, out_bus.last);
                        failed = 1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_bus.valid && in_bus.ready) ||
            (out_bus.valid && out_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress, %0d words outstanding", $time,
                         expected_words.size());
                $display("csv_row_tokenizer_unit_test: errors");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/csv_tok_pkg.sv
hw/rtl/csv_tok_if.sv
hw/rtl/csv_tok_apb.sv
hw/rtl/csv_tok_core.sv
hw/rtl/csv_tok_fifo.sv
hw/rtl/csv_row_tokenizer_unit.sv
sim/csv_row_tokenizer_unit_test.sv
